>>> rtl/first_fit_heap_allocator_defines.svh
// Assertion helpers used by the bound checker of the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define FFHA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed");

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed");

`endif

>>> rtl/ffha_pkg.sv
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_ZERO    = 3'd1;
    localparam logic [2:0] STAT_NOSPACE = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;
        logic hit;
        logic done;
    } t_dp_sts;

endpackage

>>> rtl/ffha_ctrl.sv
`timescale 1ns / 1ps

module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  ffha_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ffha_pkg::t_dp_cmd o_cmd
);

    ffha_pkg::t_state r_state;
    ffha_pkg::t_state n_state;
    logic             w_end;

    // The scan ends on a trivial request, on the first matching entry, or after the last entry.
    assign w_end = i_sts.trivial || i_sts.hit || i_sts.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ffha_pkg::S_SCAN;
                end
            end
            ffha_pkg::S_SCAN: begin
                if (w_end) begin
                    n_state = ffha_pkg::S_RESULT;
                end
            end
            ffha_pkg::S_RESULT: begin
                if (i_out_ready) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ffha_pkg::S_SCAN: begin
                o_cmd.scan   = !w_end;
                o_cmd.finish = w_end;
            end
            ffha_pkg::S_RESULT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/ffha_dp.sv
`timescale 1ns / 1ps

module ffha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffha_pkg::t_dp_cmd i_cmd,
    output ffha_pkg::t_dp_sts o_sts,
    input  logic              i_op,
    input  logic [31:0]       i_request_size,
    input  logic [31:0]       i_free_address,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    output logic [2:0]        o_status,
    output logic [31:0]       o_data_address
);

    // Block table: start offsets and lengths in memories, free marks in flops.
    logic [31:0] r_start_mem [ffha_pkg::MAX_BLOCKS];
    logic [31:0] r_len_mem   [ffha_pkg::MAX_BLOCKS];
    logic [ffha_pkg::MAX_BLOCKS-1:0] r_free;

    logic [ffha_pkg::CNT_W-1:0] r_count;
    logic [31:0]                r_heap_top;
    logic [31:0]                r_limit;

    logic        r_op;
    logic [31:0] r_size;
    logic [31:0] r_addr;

    logic [ffha_pkg::CNT_W-1:0] r_rd_idx;
    logic [ffha_pkg::IDX_W-1:0] r_cmp_idx;
    logic                       r_cmp_vld;
    logic [31:0]                r_start_q;
    logic [31:0]                r_len_q;

    logic [2:0]  r_status;
    logic [31:0] r_data_address;

    logic [32:0] w_start_hdr;
    logic [33:0] w_need_end;
    logic        w_more;
    logic        w_full;
    logic        w_nospace;
    logic        w_grow;
    logic [2:0]  n_status;
    logic [31:0] n_data_address;

    assign w_more      = r_rd_idx < r_count;
    assign w_start_hdr = {1'b0, r_start_q} + {1'b0, ffha_pkg::HDR};
    assign w_need_end  = {2'b0, r_heap_top} + {2'b0, ffha_pkg::HDR} + {2'b0, r_size};
    assign w_full      = r_count == ffha_pkg::CNT_FULL;
    assign w_nospace   = w_need_end > {2'b0, r_limit};

    always_comb begin
        o_sts.trivial = (r_op == ffha_pkg::OP_ALLOC) ? (r_size == 32'd0) : (r_addr == 32'd0);
        if (r_op == ffha_pkg::OP_ALLOC) begin
            o_sts.hit = r_cmp_vld && r_free[r_cmp_idx] && (r_len_q >= r_size);
        end else begin
            o_sts.hit = r_cmp_vld && (w_start_hdr == {1'b0, r_addr});
        end
        o_sts.done = !r_cmp_vld && !w_more;
    end

    always_comb begin
        n_status       = ffha_pkg::STAT_OK;
        n_data_address = 32'd0;
        w_grow         = 1'b0;
        if (o_sts.trivial) begin
            n_status = (r_op == ffha_pkg::OP_ALLOC) ? ffha_pkg::STAT_ZERO : ffha_pkg::STAT_OK;
        end else if (o_sts.hit) begin
            if (r_op == ffha_pkg::OP_ALLOC) begin
                n_data_address = w_start_hdr[31:0];
            end
        end else if (r_op == ffha_pkg::OP_FREE) begin
            n_status = ffha_pkg::STAT_UNKNOWN;
        end else if (w_full) begin
            n_status = ffha_pkg::STAT_FULL;
        end else if (w_nospace) begin
            n_status = ffha_pkg::STAT_NOSPACE;
        end else begin
            w_grow         = 1'b1;
            n_data_address = r_heap_top + ffha_pkg::HDR;
        end
    end

    // Table memories: one write port for growth, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_grow) begin
            r_start_mem[r_count[ffha_pkg::IDX_W-1:0]] <= r_heap_top;
            r_len_mem[r_count[ffha_pkg::IDX_W-1:0]]   <= r_size;
        end
        r_start_q <= r_start_mem[r_rd_idx[ffha_pkg::IDX_W-1:0]];
        r_len_q   <= r_len_mem[r_rd_idx[ffha_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx[ffha_pkg::IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_status       <= n_status;
            r_data_address <= n_data_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= '0;
            r_count    <= '0;
            r_heap_top <= 32'd0;
            r_limit    <= 32'd1048576;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= w_more;
                if (w_more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (i_cmd.finish && !o_sts.trivial) begin
                if (o_sts.hit) begin
                    r_free[r_cmp_idx] <= (r_op == ffha_pkg::OP_FREE);
                end else if (w_grow) begin
                    r_free[r_count[ffha_pkg::IDX_W-1:0]] <= 1'b0;
                    r_count    <= r_count + 1'b1;
                    r_heap_top <= w_need_end[31:0];
                end
            end
        end
    end

    assign o_status       = r_status;
    assign o_data_address = r_data_address;

endmodule

>>> rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// A zero-size allocate, a null free or an empty table ends the scan before any entry is compared;
// otherwise the scan stops on the first matching entry or, when no entry matches, after the
// last entry, the table holding up to 64 blocks. One request is handled at a time; the scan
// reads one entry per cycle from the single read port of the table memories, and the next
// input transaction can follow in the cycle after the result transaction. Reset (i_rst_n,
// synchronous, active low): empty table, heap top 0, heap limit 1048576.

module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] free_address
    input  logic [0:0]  s_axis_tuser,   // [0] op (0 allocate, 1 free)
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] data_address, [39:35] zero
    // Heap limit write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    ffha_pkg::t_dp_cmd w_cmd;
    ffha_pkg::t_dp_sts w_sts;
    logic [2:0]        w_status;
    logic [31:0]       w_data_address;

    // The controller sequences each request: capture, scan the table one entry per cycle,
    // then commit the decision and hold the result until the output transaction completes.
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the block table, the heap top, the block count and the limit
    // register, and it forms the first-fit, free lookup and heap growth decisions.
    ffha_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (s_axis_tuser[0]),
        .i_request_size (s_axis_tdata[31:0]),
        .i_free_address (s_axis_tdata[63:32]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_status       (w_status),
        .o_data_address (w_data_address)
    );

    // The limit register takes a write in any cycle.
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {5'd0, w_data_address, w_status};

endmodule

>>> rtl/ffha_checker.sv
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A pending result holds until the output transaction completes.
    `FFHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A new request is never taken while a result waits.
    `FFHA_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready)

    // After a request is accepted, the next one waits for its result.
    `FFHA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Every failed request reports a zero address.
    `FFHA_ASSERT_SAME(a_fail_zero, m_axis_tvalid && (m_axis_tdata[2:0] != ffha_pkg::STAT_OK),
        m_axis_tdata[34:3] == 32'd0)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

>>> dv/first_fit_heap_allocator_checker.sv
`timescale 1ns / 1ps

// Passive checker for the heap allocator. It keeps its own copy of the block table,
// predicts one result per accepted request and compares results in order.
module first_fit_heap_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] request_size, [63:32] free_address
    input  logic [0:0]  s_axis_tuser,   // [0] op (0 allocate, 1 free)
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [2:0] status, [34:3] data_address, [39:35] zero
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending
);
    import ffha_pkg::*;

    localparam logic [31:0] RESET_HEAP_LIMIT = 32'd1048576;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
    } t_heap_outcome;

    logic [31:0]   blk_start [MAX_BLOCKS];
    logic [31:0]   blk_len   [MAX_BLOCKS];
    logic          blk_free  [MAX_BLOCKS];
    int            blk_used = 0;
    logic [31:0]   heap_top = '0;
    logic [31:0]   heap_limit = RESET_HEAP_LIMIT;
    t_heap_outcome awaited_outcomes [$];
    int            mismatch_count = 0;

    task automatic report_mismatch(string msg);
        $display("%0t: heap allocator mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // First fit over the table in creation order, otherwise grow the heap.
    function automatic t_heap_outcome predict_allocate(logic [31:0] size);
        logic [63:0] need_end;
        logic [31:0] data_addr;
        if (size == 32'd0) begin
            return {STAT_ZERO, 32'd0};
        end
        for (int i = 0; i < blk_used; i++) begin
            if (blk_free[i] && blk_len[i] >= size) begin
                blk_free[i] = 1'b0;
                return {STAT_OK, blk_start[i] + HDR};
            end
        end
        if (blk_used >= MAX_BLOCKS) begin
            return {STAT_FULL, 32'd0};
        end
        need_end = {32'd0, heap_top} + {32'd0, HDR} + {32'd0, size};
        if (need_end > {32'd0, heap_limit}) begin
            return {STAT_NOSPACE, 32'd0};
        end
        blk_start[blk_used] = heap_top;
        blk_len[blk_used]   = size;
        blk_free[blk_used]  = 1'b0;
        blk_used++;
        data_addr = heap_top + HDR;
        heap_top  = need_end[31:0];
        return {STAT_OK, data_addr};
    endfunction

    function automatic t_heap_outcome predict_free(logic [31:0] addr);
        if (addr == 32'd0) begin
            return {STAT_OK, 32'd0};
        end
        for (int i = 0; i < blk_used; i++) begin
            // The match is taken without wrap, so a start near the top never aliases low.
            if ({1'b0, blk_start[i]} + {1'b0, HDR} == {1'b0, addr}) begin
                blk_free[i] = 1'b1;
                return {STAT_OK, 32'd0};
            end
        end
        return {STAT_UNKNOWN, 32'd0};
    endfunction

    task automatic check_result(logic [39:0] beat);
        t_heap_outcome want;
        if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: status %0d address %h",
                                      beat[2:0], beat[34:3]));
            return;
        end
        want = awaited_outcomes.pop_front();
        if (beat[2:0] != want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", beat[2:0], want.status));
        end
        if (beat[34:3] != want.address) begin
            report_mismatch($sformatf("data address %h, expected %h",
                                      beat[34:3], want.address));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_limit = RESET_HEAP_LIMIT;
            heap_top   = '0;
            blk_used   = 0;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                blk_free[i] = 1'b0;
            end
            awaited_outcomes.delete();
        end else begin
            // Results come from older requests, so they are checked before this edge's request.
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == OP_FREE) begin
                    awaited_outcomes.push_back(predict_free(s_axis_tdata[63:32]));
                end else begin
                    awaited_outcomes.push_back(predict_allocate(s_axis_tdata[31:0]));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                heap_limit = i_cfg_data;
            end
        end
        o_pending    <= awaited_outcomes.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

// Testbench top for the first-fit heap allocator. It drives request transactions and heap
// limit writes, applies back-pressure on the result stream, and gives the final verdict.
// All prediction and comparison lives in the checker instantiated next to the block.
module tb;
    import ffha_pkg::*;

    localparam int ITEMS_PER_PHASE  = 430;
    localparam int LONG_HOLD_CYCLES = 400;
    // The longest honest stretch without any transaction is the long hold plus one full
    // table scan; random stalls at 87 percent stay far below this.
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [63:0] s_axis_tdata = '0;     // [31:0] request_size, [63:32] free_address
    logic [0:0]  s_axis_tuser = '0;     // [0] op (0 allocate, 1 free)
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [39:0] m_axis_tdata;          // [2:0] status, [34:3] data_address, [39:35] zero
    wire         o_cfg_ready;

    int          mismatches;
    int          pending;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        long_hold_due = 1'b0;
    // Data addresses handed out so far; frees mostly pick from here so they hit real blocks.
    logic [31:0] live_addresses [$];

    first_fit_heap_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    first_fit_heap_allocator_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Result side. Each cycle the ready is drawn against the current stall rate, except during
    // a long hold, which this process counts out itself while the sender keeps offering.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Collect every nonzero data address that an allocate returned.
    always @(posedge i_clk) begin
        bit seen;
        seen = 1'b0;
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == STAT_OK
                && m_axis_tdata[34:3] != 32'd0) begin
            foreach (live_addresses[i]) begin
                if (live_addresses[i] == m_axis_tdata[34:3]) begin
                    seen = 1'b1;
                end
            end
            if (!seen) begin
                live_addresses.push_back(m_axis_tdata[34:3]);
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("first_fit_heap_allocator test failed");
        $finish;
    end

    // Offer one request and hold it until the block takes it. The valid is only lowered
    // when a gap follows, so back-to-back requests keep it high without a glitch.
    task automatic send_request(logic op, logic [31:0] size, logic [31:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {addr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    // Stop offering and wait until every awaited result has been seen, plus a short margin,
    // so that the block is idle before the heap limit changes.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_heap_limit(logic [31:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small allocations and frees of real blocks, with zero sizes, full-width sizes,
    // null frees and random addresses mixed in. The field an operation ignores is random.
    task automatic send_random_request();
        int          pick;
        int          sel;
        logic        op;
        logic [31:0] size;
        logic [31:0] addr;
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        size = $urandom;
        addr = $urandom;
        if (pick < 55) begin
            op = OP_ALLOC;
            if (sel < 4) begin
                size = 32'd0;
            end else if (sel < 10) begin
                size = $urandom;
            end else if (sel < 80) begin
                size = $urandom_range(256, 1);
            end else begin
                size = $urandom_range(4096, 257);
            end
        end else begin
            op = OP_FREE;
            if (sel < 5) begin
                addr = 32'd0;
            end else if (sel >= 20 && live_addresses.size() != 0) begin
                addr = live_addresses[$urandom_range(live_addresses.size() - 1)];
            end
        end
        send_request(op, size, addr);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, logic [31:0] limit, bit long_hold);
        settle();
        write_heap_limit(limit);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        if (long_hold) begin
            long_hold_due = 1'b1;
        end
        repeat (ITEMS_PER_PHASE) send_random_request();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset heap limit. Header size is 24, so the first block's data
        // sits at 24 and the second one's at 49.
        send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);       // zero size is rejected
        send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);        // free of null does nothing
        send_request(OP_FREE, 32'd0, 32'hFFFF_FFFF);        // unknown address
        send_request(OP_ALLOC, 32'd1, 32'd24);
        send_request(OP_ALLOC, 32'd100, 32'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd49);      // far past the heap limit
        send_request(OP_FREE, 32'd0, 32'd24);
        send_request(OP_FREE, 32'd7, 32'd24);               // double free stays legal
        send_request(OP_ALLOC, 32'd1, 32'd0);               // reuses the block at 24
        send_request(OP_FREE, 32'd0, 32'd49);
        send_request(OP_ALLOC, 32'd40, 32'd0);              // reuses 49, length stays 100
        send_request(OP_FREE, 32'd0, 32'd49);
        send_request(OP_ALLOC, 32'd100, 32'd0);             // exact fit on the kept length
        send_request(OP_FREE, 32'd0, 32'd49);
        send_request(OP_ALLOC, 32'd101, 32'd0);             // too big for 49, new block at 173
        send_request(OP_FREE, 32'd0, 32'd48);               // one byte off a real address
        settle();

        // With no room to grow, only the free block can serve an allocation.
        write_heap_limit(32'd0);
        send_request(OP_ALLOC, 32'd5, 32'd0);
        send_request(OP_ALLOC, 32'd5, 32'd0);
        settle();

        // The heap top is 274 here; a limit of 308 leaves room for exactly ten data bytes.
        write_heap_limit(32'd308);
        send_request(OP_ALLOC, 32'd11, 32'd0);
        send_request(OP_ALLOC, 32'd10, 32'd0);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        settle();

        // The end of the new block would pass 32 bits; it must still count as no space.
        write_heap_limit(32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);

        // Random phases. The first one runs at full rate against a tight limit and includes
        // the long result hold; the table normally fills up during the second one.
        run_phase(0, 0, $urandom_range(20000, 2000), 1'b1);
        run_phase(87, 0, 32'hFFFF_FFFF, 1'b0);
        run_phase(0, 87, $urandom, 1'b0);
        run_phase(31, 31, 32'd0, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("first_fit_heap_allocator test passed");
        end else begin
            $display("first_fit_heap_allocator test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
dv/first_fit_heap_allocator_checker.sv
dv/tb.sv
